FILE: rtl/atp_pkg.sv
// Shared types, constants and the color palette of the ANSI text terminal parser.
`default_nettype none

package atp_pkg;

   localparam int MAX_PARAMS  = 16;
   localparam int PARAM_W     = 12;
   localparam int CNT_W       = $clog2(MAX_PARAMS + 1);
   localparam int PIDX_W      = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int RSP_DATA_W  = 56;

   localparam logic [PARAM_W-1:0] PARAM_LIMIT = 12'd4095;

   // Output operation kinds.
   localparam logic [1:0] OP_GLYPH  = 2'd0;
   localparam logic [1:0] OP_CLEAR  = 2'd1;
   localparam logic [1:0] OP_SCROLL = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_COLUMNS  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ROWS     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SCROLL   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DEF_FG   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DEF_BG   = 3'd4;

   localparam logic [7:0]  RESET_COLUMNS = 8'd80;
   localparam logic [7:0]  RESET_ROWS    = 8'd25;
   localparam logic [31:0] RESET_DEF_FG  = 32'hFFCCCCCC;
   localparam logic [31:0] RESET_DEF_BG  = 32'hFF000000;

   // Character codes.
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_ESC   = 8'h1B;
   localparam logic [7:0] CH_LBRK  = 8'h5B;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_LOW_A = 8'h61;
   localparam logic [7:0] CH_LOW_Z = 8'h7A;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_Z  = 8'h5A;
   localparam logic [7:0] CH_M     = 8'h6D;
   localparam logic [7:0] CH_G     = 8'h47;
   localparam logic [7:0] CH_K     = 8'h4B;
   localparam logic [6:0] GLYPH_BLANK = 7'd32;

   // Cursor plan for one text byte, worked out before its words go out.
   typedef struct packed {
      logic       high;
      logic       sec_valid;
      logic [7:0] sec_col;
      logic [6:0] sec_glyph;
      logic       scroll;
      logic [7:0] new_col;
      logic [7:0] new_row;
   } text_plan_type;

   // Attribute state stepped by the SGR unit.
   typedef struct packed {
      logic [31:0] fg;
      logic [31:0] bg;
      logic        bold;
   } sgr_state_type;

   // One result word as held in the output register.
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  col;
      logic [7:0]  row;
      logic [6:0]  glyph;
      logic [31:0] color;
      logic        last;
   } rsp_word_type;

   function automatic logic [31:0] palette(input logic [3:0] idx);
      logic [31:0] c;
      unique case (idx)
         4'd0:  c = 32'hFF000000;
         4'd1:  c = 32'hFFCC0000;
         4'd2:  c = 32'hFF4E9A06;
         4'd3:  c = 32'hFFC4A000;
         4'd4:  c = 32'hFF3465A4;
         4'd5:  c = 32'hFF75507B;
         4'd6:  c = 32'hFF06989A;
         4'd7:  c = 32'hFFD3D7CF;
         4'd8:  c = 32'hFF555753;
         4'd9:  c = 32'hFFEF2929;
         4'd10: c = 32'hFF8AE234;
         4'd11: c = 32'hFFFCE94F;
         4'd12: c = 32'hFF729FCF;
         4'd13: c = 32'hFFAD7FA8;
         4'd14: c = 32'hFF34E2E2;
         default: c = 32'hFFEEEEEC;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/atp_sgr_alu.sv
// SGR step unit: applies one parameter to the current colors and bold flag.
`default_nettype none

module atp_sgr_alu (
   input  wire logic [atp_pkg::PARAM_W-1:0] param_value,
   input  wire atp_pkg::sgr_state_type      cur,
   input  wire logic [31:0]                 def_fg,
   input  wire logic [31:0]                 def_bg,
   output atp_pkg::sgr_state_type           nxt
);
   import atp_pkg::*;

   logic [3:0]         hi;
   logic [PARAM_W-1:0] off30;
   logic [PARAM_W-1:0] off40;
   logic [PARAM_W-1:0] off90;
   logic [PARAM_W-1:0] off100;

   always_comb begin
      hi     = cur.bold ? 4'd8 : 4'd0;
      off30  = param_value - PARAM_W'(30);
      off40  = param_value - PARAM_W'(40);
      off90  = param_value - PARAM_W'(90);
      off100 = param_value - PARAM_W'(100);
      nxt    = cur;
      priority if (param_value == PARAM_W'(0)) begin
         nxt.fg   = def_fg;
         nxt.bg   = def_bg;
         nxt.bold = 1'b0;
      end else if (param_value == PARAM_W'(1)) begin
         nxt.bold = 1'b1;
      end else if (param_value == PARAM_W'(22)) begin
         nxt.fg   = def_fg;
         nxt.bold = 1'b0;
      end else if (param_value >= PARAM_W'(30) && param_value <= PARAM_W'(37)) begin
         nxt.fg = palette(off30[3:0] + hi);
      end else if (param_value >= PARAM_W'(90) && param_value <= PARAM_W'(97)) begin
         nxt.fg = palette(off90[3:0] + 4'd8);
      end else if (param_value >= PARAM_W'(40) && param_value <= PARAM_W'(47)) begin
         nxt.bg = palette(off40[3:0] + hi);
      end else if (param_value >= PARAM_W'(100) && param_value <= PARAM_W'(107)) begin
         nxt.bg = palette(off100[3:0] + 4'd8);
      end else if (param_value == PARAM_W'(38)) begin
         nxt.fg = def_fg;
      end else if (param_value == PARAM_W'(48)) begin
         nxt.bg = def_bg;
      end else if (param_value == PARAM_W'(7)) begin
         nxt.fg = cur.bg;
         nxt.bg = cur.fg;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/atp_text_step.sv
// Cursor planner for a text byte: second cell, wrap and scroll decision.
`default_nettype none

module atp_text_step (
   input  wire logic [7:0]        char_byte,
   input  wire logic [7:0]        cur_col,
   input  wire logic [7:0]        cur_row,
   input  wire logic [7:0]        screen_columns,
   input  wire logic [7:0]        screen_rows,
   input  wire logic              scroll_enable,
   output atp_pkg::text_plan_type plan
);
   import atp_pkg::*;

   logic       is_bs;
   logic       is_lf;
   logic       is_cr;
   logic [8:0] pre_col;
   logic [8:0] pre_row;
   logic [8:0] wrap_col;
   logic [8:0] wrap_row;
   logic [8:0] fin_row;
   logic       row_over;

   always_comb begin
      is_bs = (char_byte == CH_BS);
      is_lf = (char_byte == CH_LF);
      is_cr = (char_byte == CH_CR);

      if (is_lf || is_cr) begin
         pre_col = 9'd0;
      end else if (is_bs) begin
         pre_col = (cur_col != 8'd0) ? {1'b0, cur_col} - 9'd1 : {1'b0, cur_col};
      end else begin
         pre_col = {1'b0, cur_col} + 9'd1;
      end
      pre_row = is_lf ? {1'b0, cur_row} + 9'd1 : {1'b0, cur_row};

      if (pre_col >= {1'b0, screen_columns}) begin
         wrap_col = 9'd0;
         wrap_row = pre_row + 9'd1;
      end else begin
         wrap_col = pre_col;
         wrap_row = pre_row;
      end

      row_over = (wrap_row >= {1'b0, screen_rows});
      if (row_over) begin
         fin_row = scroll_enable ? wrap_row - 9'd1 : 9'd0;
      end else begin
         fin_row = wrap_row;
      end

      plan.high      = char_byte[7];
      plan.sec_valid = !char_byte[7] && !is_lf && !is_cr && (!is_bs || cur_col != 8'd0);
      plan.sec_col   = is_bs ? cur_col - 8'd1 : cur_col;
      plan.sec_glyph = is_bs ? GLYPH_BLANK : char_byte[6:0];
      plan.scroll    = row_over && scroll_enable;
      plan.new_col   = wrap_col[7:0];
      plan.new_row   = fin_row[7:0];
   end

endmodule

`default_nettype wire

FILE: rtl/ansi_text_terminal_parser.sv
// Top level of the ANSI text terminal parser: sequencer, parameter memory and output register.
// The first result word of a text byte is built from the registered byte and then held in
// the output register until taken. A text byte holds the input until its one to three
// result words are out; escape, digit and separator bytes do not hold it; an SGR final holds
// it while the single SGR step unit walks its parameters behind the registered parameter read.
// Reset: configuration returns to its defaults, the cursor homes, the parser enters text mode
// and no word is pending; the parameter memory is not cleared.
`default_nettype none

module ansi_text_terminal_parser (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // Input words: tdata[7:0] char_byte.
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   input  wire logic [7:0]                      req_tdata,
   // Result words: tdata[7:0] cell_column, [15:8] cell_row, [22:16] glyph_code,
   // [54:23] cell_color, [55] zero fill.
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   output      logic [atp_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // tuser[1:0] op_kind.
   output      logic [1:0]                      rsp_tuser,
   // tlast: last_op, the final word for this byte.
   output      logic                            rsp_tlast,
   // Register write channel.
   input  wire logic                            csr_valid,
   output      logic                            csr_ready,
   input  wire logic [atp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [atp_pkg::CSR_DATA_W-1:0]  csr_data
);
   import atp_pkg::*;

   // Sequencer states.
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_BLANK  = 3'd1;
   localparam logic [2:0] ST_SECOND = 3'd2;
   localparam logic [2:0] ST_SCROLL = 3'd3;
   localparam logic [2:0] ST_CLEAR  = 3'd4;
   localparam logic [2:0] ST_SGR_RD = 3'd5;
   localparam logic [2:0] ST_SGR_EX = 3'd6;

   // Parser phases.
   localparam logic [1:0] PHASE_TEXT  = 2'd0;
   localparam logic [1:0] PHASE_ESC   = 2'd1;
   localparam logic [1:0] PHASE_PARAM = 2'd2;

   // Configuration registers.
   logic [7:0]  cols_ff, cols_in;
   logic [7:0]  rows_ff, rows_in;
   logic        scroll_en_ff, scroll_en_in;
   logic [31:0] def_fg_ff, def_fg_in;
   logic [31:0] def_bg_ff, def_bg_in;

   // Control state.
   logic [2:0]         state_ff, state_in;
   logic [1:0]         phase_ff, phase_in;
   logic [7:0]         col_ff, col_in;
   logic [7:0]         row_ff, row_in;
   sgr_state_type      attr_ff, attr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               frozen_ff, frozen_in;
   logic [CNT_W-1:0]   sgr_idx_ff, sgr_idx_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic [PARAM_W-1:0] accum_ff, accum_in;
   logic [PARAM_W-1:0] first_ff, first_in;
   logic [7:0]         byte_ff, byte_in;
   logic [7:0]         sec_col_ff, sec_col_in;
   logic [7:0]         sec_row_ff, sec_row_in;
   logic [6:0]         sec_glyph_ff, sec_glyph_in;
   logic               sec_scroll_ff, sec_scroll_in;
   rsp_word_type       rsp_word_ff, rsp_word_in;

   // The parameter memory holds up to MAX_PARAMS closed parameters; the open one stays in accum_ff.
   logic [PARAM_W-1:0] param_mem [MAX_PARAMS];
   logic [PARAM_W-1:0] mem_q_ff;
   logic               mem_we;

   logic               out_free;
   logic               in_take;
   logic [PARAM_W-1:0] first_param;
   logic [CNT_W-1:0]   walk_n;
   logic [PARAM_W-1:0] sgr_value;
   logic [PARAM_W+3:0] digit_sum;
   logic [PARAM_W-1:0] col_target;
   logic [7:0]         col_top;
   logic               is_letter;
   text_plan_type      plan;
   sgr_state_type      attr_step;

   atp_text_step u_text_step (
      .char_byte      (byte_ff),
      .cur_col        (col_ff),
      .cur_row        (row_ff),
      .screen_columns (cols_ff),
      .screen_rows    (rows_ff),
      .scroll_enable  (scroll_en_ff),
      .plan           (plan)
   );

   atp_sgr_alu u_sgr_alu (
      .param_value (sgr_value),
      .cur         (attr_ff),
      .def_fg      (def_fg_ff),
      .def_bg      (def_bg_ff),
      .nxt         (attr_step)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_word_ff.kind;
   assign rsp_tlast  = rsp_word_ff.last;
   assign rsp_tdata  = {1'b0, rsp_word_ff.color, rsp_word_ff.glyph,
                        rsp_word_ff.row, rsp_word_ff.col};

   always_comb begin
      out_free    = !rsp_valid_ff || rsp_tready;
      in_take     = req_tvalid && req_tready;
      // The first parameter is still open while no separator has been seen.
      first_param = (count_ff == CNT_W'(0)) ? accum_ff : first_ff;
      walk_n      = (count_ff < CNT_W'(MAX_PARAMS)) ? count_ff + CNT_W'(1)
                                                    : CNT_W'(MAX_PARAMS);
      sgr_value   = (sgr_idx_ff == count_ff) ? accum_ff : mem_q_ff;
      digit_sum   = {accum_ff, 3'b000} + {2'b00, accum_ff, 1'b0}
                    + (PARAM_W+4)'(req_tdata - CH_ZERO);
      col_target  = (first_param == PARAM_W'(0)) ? PARAM_W'(0)
                                                  : first_param - PARAM_W'(1);
      col_top     = (cols_ff == 8'd0) ? 8'd0 : cols_ff - 8'd1;
      is_letter   = (req_tdata >= CH_LOW_A && req_tdata <= CH_LOW_Z)
                 || (req_tdata >= CH_UP_A && req_tdata <= CH_UP_Z);
   end

   // Configuration writes.
   always_comb begin
      cols_in      = cols_ff;
      rows_in      = rows_ff;
      scroll_en_in = scroll_en_ff;
      def_fg_in    = def_fg_ff;
      def_bg_in    = def_bg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_COLUMNS: cols_in      = csr_data[7:0];
            REG_ROWS:    rows_in      = csr_data[7:0];
            REG_SCROLL:  scroll_en_in = csr_data[0];
            REG_DEF_FG:  def_fg_in    = csr_data;
            REG_DEF_BG:  def_bg_in    = csr_data;
            default: ;
         endcase
      end
   end

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      attr_in       = attr_ff;
      count_in      = count_ff;
      frozen_in     = frozen_ff;
      sgr_idx_in    = sgr_idx_ff;
      accum_in      = accum_ff;
      first_in      = first_ff;
      byte_in       = byte_ff;
      sec_col_in    = sec_col_ff;
      sec_row_in    = sec_row_ff;
      sec_glyph_in  = sec_glyph_ff;
      sec_scroll_in = sec_scroll_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      mem_we        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (in_take) begin
               byte_in = req_tdata;
               if (phase_ff == PHASE_PARAM) begin
                  if (is_letter) begin
                     phase_in = PHASE_TEXT;
                     if (req_tdata == CH_M) begin
                        sgr_idx_in   = CNT_W'(0);
                        attr_in.bold = 1'b0;
                        state_in     = ST_SGR_RD;
                     end else if (req_tdata == CH_G) begin
                        col_in = (col_target > {4'd0, col_top}) ? col_top
                                                                : col_target[7:0];
                     end else if (req_tdata == CH_K) begin
                        if (first_param == PARAM_W'(0) && col_ff < cols_ff) begin
                           state_in = ST_CLEAR;
                        end
                     end
                  end else if (req_tdata == CH_SEMI) begin
                     if (count_ff < CNT_W'(MAX_PARAMS)) begin
                        mem_we   = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                        if (count_ff == CNT_W'(0)) begin
                           first_in = accum_ff;
                        end
                     end
                     accum_in  = PARAM_W'(0);
                     frozen_in = 1'b0;
                  end else if (req_tdata >= CH_ZERO && req_tdata <= CH_NINE) begin
                     if (!frozen_ff && count_ff < CNT_W'(MAX_PARAMS)) begin
                        accum_in = (digit_sum > (PARAM_W+4)'(PARAM_LIMIT))
                                   ? PARAM_LIMIT : digit_sum[PARAM_W-1:0];
                     end
                  end else begin
                     frozen_in = 1'b1;
                  end
               end else if (phase_ff == PHASE_ESC && req_tdata == CH_LBRK) begin
                  count_in  = CNT_W'(0);
                  accum_in  = PARAM_W'(0);
                  frozen_in = 1'b0;
                  phase_in  = PHASE_PARAM;
               end else if (req_tdata == CH_ESC) begin
                  phase_in = PHASE_ESC;
               end else begin
                  phase_in = PHASE_TEXT;
                  state_in = ST_BLANK;
               end
            end
         end

         ST_BLANK: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_word_in.kind  = OP_GLYPH;
               rsp_word_in.col   = col_ff;
               rsp_word_in.row   = row_ff;
               rsp_word_in.glyph = GLYPH_BLANK;
               rsp_word_in.color = attr_ff.bg;
               rsp_word_in.last  = plan.high || (!plan.sec_valid && !plan.scroll);
               if (plan.high) begin
                  // A byte above the ASCII range only blanks the cell.
                  state_in = ST_IDLE;
               end else begin
                  col_in        = plan.new_col;
                  row_in        = plan.new_row;
                  sec_col_in    = plan.sec_col;
                  sec_row_in    = row_ff;
                  sec_glyph_in  = plan.sec_glyph;
                  sec_scroll_in = plan.scroll;
                  if (plan.sec_valid) begin
                     state_in = ST_SECOND;
                  end else if (plan.scroll) begin
                     state_in = ST_SCROLL;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end

         ST_SECOND: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_word_in.kind  = OP_GLYPH;
               rsp_word_in.col   = sec_col_ff;
               rsp_word_in.row   = sec_row_ff;
               rsp_word_in.glyph = sec_glyph_ff;
               rsp_word_in.color = attr_ff.fg;
               rsp_word_in.last  = !sec_scroll_ff;
               state_in          = sec_scroll_ff ? ST_SCROLL : ST_IDLE;
            end
         end

         ST_SCROLL: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_word_in.kind  = OP_SCROLL;
               rsp_word_in.col   = 8'd0;
               rsp_word_in.row   = 8'd0;
               rsp_word_in.glyph = 7'd0;
               rsp_word_in.color = 32'd0;
               rsp_word_in.last  = 1'b1;
               state_in          = ST_IDLE;
            end
         end

         ST_CLEAR: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_word_in.kind  = OP_CLEAR;
               rsp_word_in.col   = col_ff;
               rsp_word_in.row   = row_ff;
               rsp_word_in.glyph = GLYPH_BLANK;
               rsp_word_in.color = attr_ff.bg;
               rsp_word_in.last  = 1'b1;
               state_in          = ST_IDLE;
            end
         end

         ST_SGR_RD: begin
            // The memory read is issued here and lands in mem_q_ff.
            state_in = ST_SGR_EX;
         end

         ST_SGR_EX: begin
            attr_in    = attr_step;
            sgr_idx_in = sgr_idx_ff + CNT_W'(1);
            state_in   = (sgr_idx_ff + CNT_W'(1) == walk_n) ? ST_IDLE : ST_SGR_RD;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff      <= RESET_COLUMNS;
         rows_ff      <= RESET_ROWS;
         scroll_en_ff <= 1'b0;
         def_fg_ff    <= RESET_DEF_FG;
         def_bg_ff    <= RESET_DEF_BG;
         state_ff     <= ST_IDLE;
         phase_ff     <= PHASE_TEXT;
         col_ff       <= 8'd0;
         row_ff       <= 8'd0;
         attr_ff.fg   <= RESET_DEF_FG;
         attr_ff.bg   <= RESET_DEF_BG;
         attr_ff.bold <= 1'b0;
         count_ff     <= CNT_W'(0);
         frozen_ff    <= 1'b0;
         sgr_idx_ff   <= CNT_W'(0);
         rsp_valid_ff <= 1'b0;
      end else begin
         cols_ff      <= cols_in;
         rows_ff      <= rows_in;
         scroll_en_ff <= scroll_en_in;
         def_fg_ff    <= def_fg_in;
         def_bg_ff    <= def_bg_in;
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         attr_ff      <= attr_in;
         count_ff     <= count_in;
         frozen_ff    <= frozen_in;
         sgr_idx_ff   <= sgr_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      accum_ff      <= accum_in;
      first_ff      <= first_in;
      byte_ff       <= byte_in;
      sec_col_ff    <= sec_col_in;
      sec_row_ff    <= sec_row_in;
      sec_glyph_ff  <= sec_glyph_in;
      sec_scroll_ff <= sec_scroll_in;
      rsp_word_ff   <= rsp_word_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         param_mem[count_ff[PIDX_W-1:0]] <= accum_ff;
      end
      if (state_ff == ST_SGR_RD) begin
         mem_q_ff <= param_mem[sgr_idx_ff[PIDX_W-1:0]];
      end
   end

   // A scroll request always closes the words of its byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == OP_SCROLL |-> rsp_tlast)
      else $error("scroll word not marked last");

   // A line clear is a single blank word.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == OP_CLEAR |-> rsp_tlast && rsp_tdata[22:16] == GLYPH_BLANK)
      else $error("malformed clear word");

   // The SGR walk never steps past the parameters that were collected.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SGR_EX |-> sgr_idx_ff < walk_n)
      else $error("SGR walk overran the parameter list");

   // An escape byte in text mode always arms the sequence parser and emits nothing.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && phase_ff == PHASE_TEXT && req_tdata == CH_ESC
      |=> phase_ff == PHASE_ESC && state_ff == ST_IDLE)
      else $error("escape byte not handled");

endmodule

`default_nettype wire
